// ----- src/htanh_pkg.sv -----
// shared types, constants and the reciprocal table for the tanh block
// no dependencies
`default_nettype none

package htanh_pkg;

    localparam int unsigned QUEUE_DEPTH  = 4;
    localparam int unsigned TAYLOR_TERMS = 14;

    // magnitude thresholds in Q32
    localparam logic [37:0] SAT_LIMIT = 38'd189042323960;
    localparam logic [37:0] EXP_START = 38'd2684354560;
    // ln2 in Q40
    localparam logic [39:0] LN2_Q40   = 40'hB17217F7D2;
    localparam logic [31:0] ONE_Q31   = 32'h8000_0000;

    // rational coefficients in Q20
    localparam logic [31:0] PC0 = 32'd1693122753;
    localparam logic [31:0] PC1 = 32'd104110724;
    localparam logic [31:0] PC2 = 32'd1011246;
    localparam logic [33:0] QC0 = 34'd5079368260;
    localparam logic [33:0] QC1 = 34'd2344079475;
    localparam logic [33:0] QC2 = 34'd118291619;
    localparam logic [33:0] QC3 = 34'd1048576;

    typedef enum logic [1:0] {
        REG_RAT,
        REG_EXP,
        REG_SAT
    } t_region;

    typedef struct packed {
        logic        neg;
        t_region     region;
        logic [37:0] m;
    } t_item;

    typedef struct packed {
        logic        neg;
        t_region     region;
        logic [37:0] m;
        logic [46:0] rem;
        logic [6:0]  k;
        logic [30:0] r;
        logic [31:0] e;
        logic [31:0] x;
        logic [31:0] q0;
        logic [31:0] s;
        logic [31:0] p;
        logic [33:0] q;
        logic [31:0] ms;
    } t_work;

    typedef struct packed {
        logic        neg;
        t_region     region;
        logic        far;
        logic [31:0] m;
        logic [31:0] ms;
    } t_side;

    // floor(2^36 / n)
    function automatic logic [36:0] recip(input logic [3:0] n);
        logic [36:0] v;
        case (n)
            4'd1:    v = 37'd68719476736;
            4'd2:    v = 37'd34359738368;
            4'd3:    v = 37'd22906492245;
            4'd4:    v = 37'd17179869184;
            4'd5:    v = 37'd13743895347;
            4'd6:    v = 37'd11453246122;
            4'd7:    v = 37'd9817068105;
            4'd8:    v = 37'd8589934592;
            4'd9:    v = 37'd7635497415;
            4'd10:   v = 37'd6871947673;
            4'd11:   v = 37'd6247225157;
            4'd12:   v = 37'd5726623061;
            4'd13:   v = 37'd5286113595;
            4'd14:   v = 37'd4908534052;
            default: v = 37'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- src/htanh_front.sv -----
// front stage: takes the argument, forms the Q32 magnitude and picks the region
// depends on htanh_pkg
`default_nettype none

module htanh_front #(
    parameter int unsigned IN_FRAC_BITS = 24
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire  [31:0]         i_arg,
    output logic                o_valid,
    input  wire                 i_ready,
    output htanh_pkg::t_item    o_item
);
    import htanh_pkg::*;

    localparam int unsigned SH = 32 - IN_FRAC_BITS;

    logic        r_valid;
    t_item       r_item;
    t_item       n_item;
    logic [31:0] mag;
    logic [63:0] m_full;

    always_comb begin
        mag    = i_arg[31] ? (32'd0 - i_arg) : i_arg;
        m_full = {32'd0, mag} << SH;
        n_item.neg = i_arg[31];
        n_item.m   = m_full[37:0];
        if (m_full > {26'd0, SAT_LIMIT}) begin
            n_item.region = REG_SAT;
        end else if (m_full[37:0] >= EXP_START) begin
            n_item.region = REG_EXP;
        end else begin
            n_item.region = REG_RAT;
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

// ----- src/htanh_fifo.sv -----
// short queue between the front stage and the arithmetic pipeline
// depends on htanh_pkg
`default_nettype none

module htanh_fifo (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  htanh_pkg::t_item    i_item,
    output logic                o_valid,
    input  wire                 i_ready,
    output htanh_pkg::t_item    o_item
);
    import htanh_pkg::*;

    localparam int unsigned PW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    t_item          r_mem [QUEUE_DEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [CW-1:0]  r_cnt;
    logic           push;
    logic           pop;

    assign o_valid = r_cnt != '0;
    assign pop     = o_valid && i_ready;
    assign o_ready = (r_cnt != CW'(QUEUE_DEPTH)) || pop;
    assign push    = i_valid && o_ready;
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + PW'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ----- src/htanh_div.sv -----
// pipelined restoring divider, one quotient bit per stage, 32 stages
// depends on htanh_pkg
`default_nettype none

module htanh_div (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire                 i_valid,
    input  wire  [64:0]         i_rem,
    input  wire  [31:0]         i_low,
    input  wire  [64:0]         i_den,
    input  htanh_pkg::t_side    i_side,
    output logic                o_valid,
    output logic [31:0]         o_quo,
    output htanh_pkg::t_side    o_side
);
    import htanh_pkg::*;

    localparam int unsigned NS = 32;

    logic        r_v    [NS];
    logic [64:0] r_rem  [NS];
    logic [31:0] r_low  [NS];
    logic [64:0] r_den  [NS];
    logic [31:0] r_quo  [NS];
    t_side       r_side [NS];

    for (genvar i = 0; i < NS; i++) begin : g_stage
        logic [64:0] p_rem;
        logic [31:0] p_low;
        logic [64:0] p_den;
        logic [31:0] p_quo;
        t_side       p_side;
        logic        p_v;
        logic [65:0] sh;
        logic [65:0] diff;
        logic        take;

        always_comb begin
            if (i == 0) begin
                p_rem  = i_rem;
                p_low  = i_low;
                p_den  = i_den;
                p_quo  = '0;
                p_side = i_side;
                p_v    = i_valid;
            end else begin
                p_rem  = r_rem[(i == 0) ? 0 : i - 1];
                p_low  = r_low[(i == 0) ? 0 : i - 1];
                p_den  = r_den[(i == 0) ? 0 : i - 1];
                p_quo  = r_quo[(i == 0) ? 0 : i - 1];
                p_side = r_side[(i == 0) ? 0 : i - 1];
                p_v    = r_v[(i == 0) ? 0 : i - 1];
            end
            sh   = {p_rem, p_low[31]};
            diff = sh - {1'b0, p_den};
            take = sh >= {1'b0, p_den};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i] <= 1'b0;
            end else if (i_en) begin
                r_v[i] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i]  <= take ? diff[64:0] : sh[64:0];
                r_low[i]  <= {p_low[30:0], 1'b0};
                r_den[i]  <= p_den;
                r_quo[i]  <= {p_quo[30:0], take};
                r_side[i] <= p_side;
            end
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_quo   = r_quo[NS-1];
    assign o_side  = r_side[NS-1];

endmodule

`default_nettype wire

// ----- src/htanh_back.sv -----
// arithmetic pipeline: range reduction, exp series, rational terms, divide, correction product, output register
// depends on htanh_pkg and htanh_div
`default_nettype none

module htanh_back #(
    parameter int unsigned OUT_FRAC_BITS = 30
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  htanh_pkg::t_item    i_item,
    output logic                o_pop,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic [31:0]         o_tanh_value
);
    import htanh_pkg::*;

    localparam int unsigned NA = 8;
    localparam int unsigned NH = 3 * TAYLOR_TERMS;

    logic        adv;
    logic        r_av [NA];
    t_work       r_a  [NA];
    logic        r_hv [NH];
    t_work       r_h  [NH];
    t_work       n_a0;

    assign adv   = !o_valid || i_ready;
    assign o_pop = adv;

    // stage 0 takes the queued item
    always_comb begin
        n_a0        = '0;
        n_a0.neg    = i_item.neg;
        n_a0.region = i_item.region;
        n_a0.m      = i_item.m;
        n_a0.rem    = {i_item.m, 9'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av[0] <= 1'b0;
        end else if (adv) begin
            r_av[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a[0] <= n_a0;
        end
    end

    // stages 1..7: 2z / ln2 one bit a stage, rational polynomials alongside
    for (genvar j = 1; j < NA; j++) begin : g_red
        t_work       nx;
        t_work       pv;
        logic [46:0] sub;
        logic [65:0] pp;
        logic [65:0] qp;
        logic [63:0] mp;

        always_comb begin
            pv  = r_a[j-1];
            nx  = pv;
            sub = 47'(LN2_Q40) << (7 - j);
            pp  = '0;
            qp  = '0;
            mp  = '0;
            if (pv.rem >= sub) begin
                nx.rem      = pv.rem - sub;
                nx.k[7 - j] = 1'b1;
            end
            if (j == NA - 1) begin
                nx.r = nx.rem[39:9];
                nx.e = ONE_Q31;
            end
            if (j == 1) begin
                mp   = 64'(pv.m[31:0]) * 64'(pv.m[31:0]);
                nx.s = mp[63:32];
            end else if (j == 2) begin
                pp   = 66'(PC2) * 66'(pv.s);
                qp   = 66'(QC3) * 66'(pv.s);
                nx.p = pp[63:32] + PC1;
                nx.q = 34'(qp[65:32]) + QC2;
            end else if (j == 3) begin
                pp   = 66'(pv.p) * 66'(pv.s);
                qp   = 66'(pv.q) * 66'(pv.s);
                nx.p = pp[63:32] + PC0;
                nx.q = 34'(qp[65:32]) + QC1;
            end else if (j == 4) begin
                qp    = 66'(pv.q) * 66'(pv.s);
                mp    = 64'(pv.m[31:0]) * 64'(pv.s);
                nx.q  = 34'(qp[65:32]) + QC0;
                nx.ms = mp[63:32];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_av[j] <= 1'b0;
            end else if (adv) begin
                r_av[j] <= r_av[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_a[j] <= nx;
            end
        end
    end

    // exp series: per term multiply, reciprocal multiply, correction
    for (genvar h = 0; h < NH; h++) begin : g_exp
        localparam logic [3:0] NT = 4'(TAYLOR_TERMS - h / 3);
        t_work       nx;
        t_work       pv;
        logic        pvv;
        logic [63:0] er;
        logic [68:0] xr;
        logic [31:0] qn;
        logic [31:0] rm;
        logic [31:0] qc;

        always_comb begin
            if (h == 0) begin
                pv  = r_a[NA-1];
                pvv = r_av[NA-1];
            end else begin
                pv  = r_h[(h == 0) ? 0 : h - 1];
                pvv = r_hv[(h == 0) ? 0 : h - 1];
            end
            nx = pv;
            er = '0;
            xr = '0;
            qn = '0;
            rm = '0;
            qc = '0;
            if (h % 3 == 0) begin
                er   = 64'(pv.e) * 64'(pv.r);
                nx.x = er[62:31];
            end else if (h % 3 == 1) begin
                xr    = 69'(pv.x) * 69'(recip(NT));
                nx.q0 = xr[67:36];
            end else begin
                qn   = 32'(pv.q0 * NT);
                rm   = pv.x - qn;
                qc   = (rm >= 32'(NT)) ? pv.q0 + 32'd1 : pv.q0;
                nx.e = ONE_Q31 + qc;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_hv[h] <= 1'b0;
            end else if (adv) begin
                r_hv[h] <= pvv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_h[h] <= nx;
            end
        end
    end

    // divider operands: (2^(32+F) + D/2) / D for exp, (P << 32) / Q for rational
    logic        r_xv;
    logic [64:0] r_xrem;
    logic [31:0] r_xlow;
    logic [64:0] r_xden;
    t_side       r_xside;
    t_work       hl;
    logic [64:0] den_e;
    logic [65:0] num_e;
    t_side       n_side;

    always_comb begin
        hl            = r_h[NH-1];
        den_e         = (65'(hl.e) << hl.k[5:0]) + 65'(ONE_Q31);
        num_e         = (66'd1 << (32 + OUT_FRAC_BITS)) + 66'(den_e >> 1);
        n_side.neg    = hl.neg;
        n_side.region = hl.region;
        n_side.far    = hl.k > 7'd32;
        n_side.m      = hl.m[31:0];
        n_side.ms     = hl.ms;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xv <= 1'b0;
        end else if (adv) begin
            r_xv <= r_hv[NH-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_xside <= n_side;
            if (hl.region == REG_EXP) begin
                r_xrem <= 65'(num_e[65:32]);
                r_xlow <= num_e[31:0];
                r_xden <= den_e;
            end else begin
                r_xrem <= 65'(hl.p);
                r_xlow <= '0;
                r_xden <= 65'(hl.q);
            end
        end
    end

    logic        dv;
    logic [31:0] quo;
    t_side       dside;

    htanh_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_xv),
        .i_rem   (r_xrem),
        .i_low   (r_xlow),
        .i_den   (r_xden),
        .i_side  (r_xside),
        .o_valid (dv),
        .o_quo   (quo),
        .o_side  (dside)
    );

    // exp magnitude, or the correction product for the rational region
    logic        r_pv;
    t_side       r_pside;
    logic [31:0] r_pval;
    logic [63:0] cp;
    logic [31:0] n_pval;

    always_comb begin
        cp = 64'(dside.ms) * 64'(quo);
        if (dside.region == REG_EXP) begin
            n_pval = (32'd1 << OUT_FRAC_BITS) - (dside.far ? 32'd0 : quo);
        end else begin
            n_pval = cp[63:32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (adv) begin
            r_pv <= dv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pside <= dside;
            r_pval  <= n_pval;
        end
    end

    // output register
    logic        r_out_valid;
    logic [31:0] r_out_data;
    logic [31:0] vdiff;
    logic [32:0] vrnd;
    logic [31:0] res;

    always_comb begin
        vdiff = r_pside.m - r_pval;
        vrnd  = 33'(vdiff) + (33'd1 << (31 - OUT_FRAC_BITS));
        case (r_pside.region)
            REG_SAT: res = 32'd1 << OUT_FRAC_BITS;
            REG_EXP: res = r_pval;
            REG_RAT: res = 32'(vrnd >> (32 - OUT_FRAC_BITS));
            default: res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data <= r_pside.neg ? (32'd0 - res) : res;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_tanh_value = r_out_data;

endmodule

`default_nettype wire

// ----- src/hyperbolic_tangent.sv -----
// top level of the fixed-point tanh block: front stage, queue and arithmetic pipeline
// depends on htanh_pkg, htanh_front, htanh_fifo, htanh_back
`default_nettype none

// channel   | direction | tdata fields (low bit first)
// ----------+-----------+-------------------------------------------
// s_axis    | in        | arg [31:0], signed Q8.24 by default
// m_axis    | out       | tanh_value [31:0], signed Q2.30 by default
//
// one beat accepted per cycle while the front stage can take it; each result passes
// through the 7-stage ln2 reduction, the 42-stage exp series
// (multiply, reciprocal multiply, correction per term) and the 32-stage divider
// reset clears all valid flags and the queue; no memory to sweep
// a stall on m_axis freezes the arithmetic pipeline; the front stage and the
// four-entry queue keep taking beats until they fill

module hyperbolic_tangent #(
    parameter int unsigned IN_FRAC_BITS  = 24,
    parameter int unsigned OUT_FRAC_BITS = 30
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // arg
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata    // tanh_value
);
    import htanh_pkg::*;

    logic  front_valid;
    t_item front_item;
    logic  fifo_ready;
    logic  fifo_valid;
    t_item fifo_item;
    logic  back_pop;

    // sign, Q32 magnitude and region
    htanh_front #(
        .IN_FRAC_BITS (IN_FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_arg   (s_axis_tdata),
        .o_valid (front_valid),
        .i_ready (fifo_ready),
        .o_item  (front_item)
    );

    // decouples the front stage from pipeline stalls
    htanh_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (fifo_ready),
        .i_item  (front_item),
        .o_valid (fifo_valid),
        .i_ready (back_pop),
        .o_item  (fifo_item)
    );

    // exp series and rational terms computed side by side, region picks the divider operands and the result
    htanh_back #(
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (fifo_valid),
        .i_item       (fifo_item),
        .o_pop        (back_pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_tanh_value (m_axis_tdata)
    );

    // result never exceeds full scale
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata) <= $signed(32'd1 << OUT_FRAC_BITS)
                       && $signed(m_axis_tdata) >= -$signed(32'd1 << OUT_FRAC_BITS)))
        else $error("tanh result out of range");

    // no stale beat right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // queue is held only while m_axis stalls
    a_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fifo_valid && !back_pop) |-> (m_axis_tvalid && !m_axis_tready))
        else $error("queue held while pipeline free");

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// testbench for the fixed-point tanh block: directed table, then random stream
// depends on htanh_pkg and hyperbolic_tangent; predicts results in 64-bit arithmetic unless a row types one in
`timescale 1ns / 100ps
`default_nettype none

module tb_top;

    localparam int unsigned IN_FB  = 24;
    localparam int unsigned OUT_FB = 30;
    localparam int N_RANDOM = 950;
    localparam int LATENCY  = 87;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;    // arg
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // tanh_value

    hyperbolic_tangent #(.IN_FRAC_BITS(IN_FB), .OUT_FRAC_BITS(OUT_FB)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    logic [31:0] tanh_expected[$];
    int errors = 0;

    // exponential region: 1 - 2/(e^2z + 1), magnitude in output format
    function automatic logic [63:0] tanh_exp_mag(input logic [63:0] m);
        logic [63:0] y, k, r, e, den, d;
        y = m << 9;
        k = y / htanh_pkg::LN2_Q40;
        r = (y - k * htanh_pkg::LN2_Q40) >> 9;
        e = htanh_pkg::ONE_Q31;
        for (int n = htanh_pkg::TAYLOR_TERMS; n >= 1; n--)
            e = htanh_pkg::ONE_Q31 + ((e * r) >> 31) / n;
        d = 0;
        if (k <= 32) begin
            den = (e << k) + htanh_pkg::ONE_Q31;
            d = ((64'd1 << (32 + OUT_FB)) + den / 2) / den;
        end
        return (64'd1 << OUT_FB) - d;
    endfunction

    // small-argument region: z - z*s*P/Q
    function automatic logic [63:0] tanh_rat_mag(input logic [63:0] m);
        logic [63:0] s, p, q, ratio, c, v;
        s = (m * m) >> 32;
        p = htanh_pkg::PC2;
        p = ((p * s) >> 32) + htanh_pkg::PC1;
        p = ((p * s) >> 32) + htanh_pkg::PC0;
        q = htanh_pkg::QC3;
        q = ((q * s) >> 32) + htanh_pkg::QC2;
        q = ((q * s) >> 32) + htanh_pkg::QC1;
        q = ((q * s) >> 32) + htanh_pkg::QC0;
        ratio = (p << 32) / q;
        c = (((m * s) >> 32) * ratio) >> 32;
        v = m - c;
        return (v + (64'd1 << (31 - OUT_FB))) >> (32 - OUT_FB);
    endfunction

    function automatic logic [31:0] tanh_fixed(input logic [31:0] arg);
        logic [63:0] mag, m, res;
        mag = arg[31] ? (64'h1_0000_0000 - {32'd0, arg}) : {32'd0, arg};
        m = mag << (32 - IN_FB);
        if (m > htanh_pkg::SAT_LIMIT) res = 64'd1 << OUT_FB;
        else if (m >= htanh_pkg::EXP_START) res = tanh_exp_mag(m);
        else res = tanh_rat_mag(m);
        if (arg[31]) res = 64'd0 - res;
        return res[31:0];
    endfunction

    // one beat on s_axis after a random gap; known gives a typed-in result
    task automatic send_arg(input logic [31:0] arg, input bit known, input logic [31:0] res);
        int gap;
        gap = $urandom_range(0, 10);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= arg;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        tanh_expected.push_back(known ? res : tanh_fixed(arg));
    endtask

    typedef struct { logic [31:0] arg; bit known; logic [31:0] res; } t_row;
    t_row dir_table[] = '{
        '{32'h0000_0000, 1'b1, 32'h0000_0000},   // zero
        '{32'h8000_0000, 1'b1, 32'hC000_0000},   // most negative, saturates
        '{32'h7FFF_FFFF, 1'b1, 32'h4000_0000},   // most positive
        '{32'h2C04_0000, 1'b1, 32'h4000_0000},   // just above saturation limit
        '{32'hD3FC_0000, 1'b1, 32'hC000_0000},
        '{32'h2C00_0000, 1'b0, 32'h0},           // near limit, exp region
        '{32'h1800_0000, 1'b0, 32'h0},           // far tail, k above 32
        '{32'h0A00_0000, 1'b0, 32'h0},
        '{32'h009F_FFFF, 1'b0, 32'h0},           // just below 0.625
        '{32'h00A0_0000, 1'b0, 32'h0},           // exactly 0.625
        '{32'hFF60_0000, 1'b0, 32'h0},
        '{32'hFF60_0001, 1'b0, 32'h0},
        '{32'h0000_0001, 1'b0, 32'h0},           // smallest step
        '{32'hFFFF_FFFF, 1'b0, 32'h0},
        '{32'h0100_0000, 1'b0, 32'h0},           // one
        '{32'hFF00_0000, 1'b0, 32'h0},
        '{32'h0040_0000, 1'b0, 32'h0},
        '{32'h0200_0000, 1'b0, 32'h0}
    };

    // output side: random stalls, compare against oldest expectation
    initial begin
        logic [31:0] want;
        int gap;
        @(posedge i_rst_n);
        forever begin
            gap = $urandom_range(0, 10);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            if (tanh_expected.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected beat: got %h", m_axis_tdata);
            end else begin
                want = tanh_expected.pop_front();
                if (want !== m_axis_tdata) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected %h actual %h", want, m_axis_tdata);
                end
            end
        end
    end

    // stimulus
    initial begin
        logic [31:0] a;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (dir_table[i]) send_arg(dir_table[i].arg, dir_table[i].known, dir_table[i].res);
        s_axis_tvalid <= 1'b0;
        // hold off until the pipeline has drained
        while (tanh_expected.size() != 0) @(posedge i_clk);
        for (int i = 0; i < N_RANDOM; i++) begin
            case ($urandom_range(0, 3))
                0: a = $urandom();                                        // any bits
                1: a = $urandom_range(0, 32'h00A0_0000);                  // rational region, plus 0.625 itself
                2: a = $urandom_range(32'h00A0_0000, 32'h2C05_0000);      // exp region, up into saturation
                default: a = $urandom_range(32'h0090_0000, 32'h00B0_0000); // around 0.625
            endcase
            if ($urandom_range(0, 1)) a = 32'd0 - a;
            // some runs go back to back
            if (i % 200 < 30) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= a;
                @(posedge i_clk);
                while (!s_axis_tready) @(posedge i_clk);
                tanh_expected.push_back(tanh_fixed(a));
            end else begin
                send_arg(a, 1'b0, 32'h0);
            end
        end
        s_axis_tvalid <= 1'b0;
        while (tanh_expected.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (errors == 0 && tanh_expected.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
